FILE: design/cisa_pkg.sv
// ============================================================================
// cisa_pkg
// Shared types, codes and constants of the circular identifier slot allocator.
// ============================================================================
package cisa_pkg;

    // default highest identifier handed out
    localparam int MAX_ID_DEF = 127;

    // occupancy words: width and log2 of the width
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    // action codes
    localparam logic [2:0] ACT_ALLOC   = 3'd0;
    localparam logic [2:0] ACT_PROBE   = 3'd1;
    localparam logic [2:0] ACT_PLACE   = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_LOOKUP  = 3'd4;

    // status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_INVALID   = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // request payload
    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  slot_id;
        logic [31:0] owner_handle;
    } t_req;

    // response payload
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  result_id;
        logic [31:0] owner_out;
    } t_rsp;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ID_EV,
        S_SRCH_RD,
        S_SRCH_EV,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clr_wr;
        logic load_req;
        logic rd_srch;
        logic srch_init;
        logic srch_adv;
        logic srch_hit;
        logic srch_full;
        logic id_exec;
        logic res_invalid;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic       clr_last;
        logic [2:0] action;
        logic       id_ok;
        logic       found;
        logic       srch_end;
        logic       out_busy;
    } t_sts;

endpackage

FILE: design/cisa_ctrl.sv
// ============================================================================
// cisa_ctrl
// Controller state machine: clearing pass, request decode, word-by-word
// free search sequencing and response hand-off.
// ============================================================================
module cisa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cisa_pkg::t_sts  i_sts,
    output cisa_pkg::t_cmd  o_cmd
);

    cisa_pkg::t_state r_state;
    cisa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cisa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // only the idle state takes a request
    assign o_in_stall = (r_state != cisa_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            cisa_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = cisa_pkg::S_IDLE;
                end
            end
            cisa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = cisa_pkg::S_DECODE;
                end
            end
            cisa_pkg::S_DECODE: begin
                case (i_sts.action)
                    cisa_pkg::ACT_ALLOC,
                    cisa_pkg::ACT_PROBE: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = cisa_pkg::S_SRCH_RD;
                    end
                    cisa_pkg::ACT_PLACE,
                    cisa_pkg::ACT_RELEASE,
                    cisa_pkg::ACT_LOOKUP: begin
                        if (i_sts.id_ok) begin
                            n_state = cisa_pkg::S_ID_EV;
                        end else begin
                            o_cmd.res_invalid = 1'b1;
                            n_state           = cisa_pkg::S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.res_invalid = 1'b1;
                        n_state           = cisa_pkg::S_DONE;
                    end
                endcase
            end
            cisa_pkg::S_ID_EV: begin
                o_cmd.id_exec = 1'b1;
                n_state       = cisa_pkg::S_DONE;
            end
            cisa_pkg::S_SRCH_RD: begin
                o_cmd.rd_srch = 1'b1;
                n_state       = cisa_pkg::S_SRCH_EV;
            end
            cisa_pkg::S_SRCH_EV: begin
                if (i_sts.found) begin
                    o_cmd.srch_hit = 1'b1;
                    n_state        = cisa_pkg::S_DONE;
                end else if (i_sts.srch_end) begin
                    o_cmd.srch_full = 1'b1;
                    n_state         = cisa_pkg::S_DONE;
                end else begin
                    o_cmd.srch_adv = 1'b1;
                    n_state        = cisa_pkg::S_SRCH_RD;
                end
            end
            cisa_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = cisa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cisa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/cisa_dp.sv
// ============================================================================
// cisa_dp
// Datapath: occupancy word memory, owner memory, rotating free search over
// one word per step, last-given register and the response register.
// ============================================================================
module cisa_dp #(
    parameter int MAX_ID = cisa_pkg::MAX_ID_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cisa_pkg::t_req  i_in_data,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output cisa_pkg::t_rsp  o_out_data,
    input  cisa_pkg::t_cmd  i_cmd,
    output cisa_pkg::t_sts  o_sts
);

    localparam int ID_W = $clog2(MAX_ID + 1);
    localparam int WW   = cisa_pkg::WORD_W;
    localparam int BW   = cisa_pkg::WORD_SH;
    localparam int NW   = (MAX_ID + WW) / WW;
    localparam int WA_W = (NW > 1) ? $clog2(NW) : 1;
    localparam int FW   = WA_W + BW;
    localparam int CW   = (ID_W > 7) ? ID_W : 7;

    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NW - 1);
    localparam logic [FW-1:0]   MAX_F     = FW'(MAX_ID);
    localparam logic [CW-1:0]   MAX_C     = CW'(MAX_ID);
    localparam logic [ID_W-1:0] MAX_I     = ID_W'(MAX_ID);

    // memories
    logic [WW-1:0] r_taken_mem [0:NW-1];
    logic [31:0]   r_owner_mem [0:MAX_ID];

    cisa_pkg::t_req  r_req;
    cisa_pkg::t_rsp  r_res;
    cisa_pkg::t_rsp  r_out;
    logic            r_out_valid;
    logic [ID_W-1:0] r_last;
    logic [WA_W-1:0] r_wptr;
    logic            r_pass;
    logic [WA_W-1:0] r_clr_ptr;
    logic [WW-1:0]   r_rd_word;
    logic [31:0]     r_owner_rd;

    logic [ID_W-1:0] req_id;
    logic            id_ok;
    logic [ID_W-1:0] start_id;
    logic [WA_W-1:0] start_word;
    logic [WA_W-1:0] id_word;
    logic [BW-1:0]   id_bit;
    logic [WW-1:0]   id_onehot;
    logic            id_taken;
    logic [WW-1:0]   srch_mask;
    logic [WW-1:0]   free_vec;
    logic            found;
    logic [BW-1:0]   hit_bit;
    logic [ID_W-1:0] hit_id;
    logic [WW-1:0]   hit_onehot;
    logic [FW-1:0]   cand_id;
    logic [WA_W-1:0] rd_addr;
    logic            wr_en;
    logic [WA_W-1:0] wr_addr;
    logic [WW-1:0]   wr_data;
    logic            own_we;
    logic [ID_W-1:0] own_addr;
    logic            is_alloc;

    // request identifier decode
    assign req_id    = ID_W'(r_req.slot_id);
    assign id_ok     = (r_req.slot_id != 7'd0) && (CW'(r_req.slot_id) <= MAX_C);
    assign id_word   = WA_W'(req_id >> BW);
    assign id_bit    = BW'(req_id);
    assign id_onehot = WW'(1) << id_bit;
    assign id_taken  = |(r_rd_word & id_onehot);
    assign is_alloc  = (r_req.action == cisa_pkg::ACT_ALLOC);

    // search starts just after the last identifier given, wrapping to 1
    assign start_id   = (r_last >= MAX_I) ? ID_W'(1) : r_last + ID_W'(1);
    assign start_word = WA_W'(start_id >> BW);

    // candidate mask of the current word: first lap from start, second from 1
    always_comb begin
        srch_mask = '0;
        cand_id   = '0;
        for (int b = 0; b < WW; b++) begin
            cand_id      = {r_wptr, BW'(b)};
            srch_mask[b] = (cand_id <= MAX_F) &&
                           (r_pass ? (cand_id != '0) : (cand_id >= FW'(start_id)));
        end
    end

    assign free_vec = ~r_rd_word & srch_mask;
    assign found    = |free_vec;

    // lowest free bit of the word
    always_comb begin
        hit_bit = '0;
        for (int b = WW - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                hit_bit = BW'(b);
            end
        end
    end

    assign hit_id     = ID_W'({r_wptr, hit_bit});
    assign hit_onehot = WW'(1) << hit_bit;

    // occupancy write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = id_word;
        wr_data = r_rd_word;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_ptr;
            wr_data = '0;
        end else if (i_cmd.srch_hit && is_alloc) begin
            wr_en   = 1'b1;
            wr_addr = r_wptr;
            wr_data = r_rd_word | hit_onehot;
        end else if (i_cmd.id_exec && (r_req.action == cisa_pkg::ACT_PLACE)) begin
            wr_en   = 1'b1;
            wr_data = r_rd_word | id_onehot;
        end else if (i_cmd.id_exec && (r_req.action == cisa_pkg::ACT_RELEASE)) begin
            wr_en   = 1'b1;
            wr_data = r_rd_word & ~id_onehot;
        end
    end

    assign rd_addr  = i_cmd.rd_srch ? r_wptr : id_word;
    assign own_we   = (i_cmd.srch_hit && is_alloc) ||
                      (i_cmd.id_exec && (r_req.action == cisa_pkg::ACT_PLACE));
    assign own_addr = i_cmd.srch_hit ? hit_id : req_id;

    // occupancy memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_taken_mem[wr_addr] <= wr_data;
        end
        r_rd_word <= r_taken_mem[rd_addr];
    end

    // owner memory
    always_ff @(posedge i_clk) begin
        if (own_we) begin
            r_owner_mem[own_addr] <= r_req.owner_handle;
        end
        r_owner_rd <= r_owner_mem[req_id];
    end

    // control registers: clear pointer, search pointer, last given, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr   <= '0;
            r_wptr      <= '0;
            r_pass      <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_ptr <= r_clr_ptr + WA_W'(1);
            end
            if (i_cmd.srch_init) begin
                r_wptr <= start_word;
                r_pass <= 1'b0;
            end else if (i_cmd.srch_adv) begin
                if (r_wptr == LAST_WORD) begin
                    r_wptr <= '0;
                    r_pass <= 1'b1;
                end else begin
                    r_wptr <= r_wptr + WA_W'(1);
                end
            end
            if (i_cmd.srch_hit && is_alloc) begin
                r_last <= hit_id;
            end else if (i_cmd.id_exec && (r_req.action == cisa_pkg::ACT_PLACE)) begin
                r_last <= req_id;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, result build and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
        end
        if (i_cmd.res_invalid) begin
            r_res.status    <= cisa_pkg::STS_INVALID;
            r_res.result_id <= '0;
            r_res.owner_out <= '0;
        end else if (i_cmd.srch_full) begin
            r_res.status    <= cisa_pkg::STS_FULL;
            r_res.result_id <= '0;
            r_res.owner_out <= '0;
        end else if (i_cmd.srch_hit) begin
            r_res.status    <= cisa_pkg::STS_OK;
            r_res.result_id <= 7'(hit_id);
            r_res.owner_out <= '0;
        end else if (i_cmd.id_exec) begin
            r_res.result_id <= '0;
            r_res.owner_out <= '0;
            case (r_req.action)
                cisa_pkg::ACT_PLACE: begin
                    r_res.status    <= cisa_pkg::STS_OK;
                    r_res.result_id <= r_req.slot_id;
                end
                cisa_pkg::ACT_RELEASE: begin
                    r_res.status <= cisa_pkg::STS_OK;
                end
                cisa_pkg::ACT_LOOKUP: begin
                    if (id_taken) begin
                        r_res.status    <= cisa_pkg::STS_OK;
                        r_res.owner_out <= r_owner_rd;
                    end else begin
                        r_res.status <= cisa_pkg::STS_NOT_FOUND;
                    end
                end
                default: begin
                    r_res.status <= cisa_pkg::STS_INVALID;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // status to controller
    always_comb begin
        o_sts.clr_last = (r_clr_ptr == LAST_WORD);
        o_sts.action   = r_req.action;
        o_sts.id_ok    = id_ok;
        o_sts.found    = found;
        o_sts.srch_end = r_pass && (r_wptr == start_word);
        o_sts.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/circular_id_slot_allocator_top.sv
// ============================================================================
// circular_id_slot_allocator_top
// Next-fit circular identifier allocator with owner table.
// ============================================================================
// Identifiers 1..MAX_ID are handed out next-fit, starting just after the last
// identifier allocated or placed and wrapping to 1 over one full lap; 0 is
// never given. One request is worked at a time and yields one response.
// Place, release and lookup go through decode, one identifier evaluation
// and the response state; requests rejected for a bad identifier or an
// unused action code go from decode straight to the response state.
// Allocate and probe scan the occupancy memory one 32-bit word at a time
// (read, then evaluate), visiting from 1 to ceil((MAX_ID+1)/32)+1 words.
// The next request is taken while a finished response still waits in the
// output register. After reset a clearing pass zeroes the occupancy memory
// while no request is taken. A lookup of a free identifier returns not
// found; owner data is only read from taken slots.
// ============================================================================
module circular_id_slot_allocator_top #(
    parameter int MAX_ID = cisa_pkg::MAX_ID_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  cisa_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cisa_pkg::t_rsp  o_out_data
);

    cisa_pkg::t_cmd cmd;
    cisa_pkg::t_sts sts;

    // controller
    cisa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath
    cisa_dp #(
        .MAX_ID (MAX_ID)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
